// ===== src/pta_pkg.sv =====
// Shared types and constants for triangle primitive assembly.
package pta_pkg;

	localparam int VERTEX_BITS = 32;
	localparam int MAX_RESULTS = 7;
	localparam int NUM_BITS    = 3;

	localparam logic [3:0] TYPE_TRI       = 4'd0;
	localparam logic [3:0] TYPE_QUAD      = 4'd1;
	localparam logic [3:0] TYPE_QUAD2     = 4'd2;
	localparam logic [3:0] TYPE_STRIP     = 4'd3;
	localparam logic [3:0] TYPE_FAN       = 4'd4;
	localparam logic [3:0] TYPE_LINES     = 4'd5;
	localparam logic [3:0] TYPE_LINESTRIP = 4'd6;
	localparam logic [3:0] TYPE_POINTS    = 4'd7;

	localparam logic [2:0] STATUS_OK          = 3'd0;
	localparam logic [2:0] STATUS_TRI_COUNT   = 3'd1;
	localparam logic [2:0] STATUS_QUAD_COUNT  = 3'd2;
	localparam logic [2:0] STATUS_SHORT_STRIP = 3'd3;
	localparam logic [2:0] STATUS_SHORT_FAN   = 3'd4;
	localparam logic [2:0] STATUS_NON_TRI     = 3'd5;
	localparam logic [2:0] STATUS_UNKNOWN     = 3'd6;

	typedef logic [VERTEX_BITS-1:0] vertex_t;
	typedef logic [NUM_BITS-1:0]    num_t;

	typedef struct packed {
		vertex_t    vertex_ref;
		logic [3:0] prim_type;
		logic       prim_first;
		logic       prim_last;
	} vertex_in_t;

	typedef struct packed {
		vertex_t    out_vertex;
		logic       carries_vertex;
		logic [2:0] status_code;
		logic       last;
	} result_t;

	typedef result_t [MAX_RESULTS-1:0] burst_t;

endpackage

// ===== src/pta_assemble.sv =====
// Primitive state registers and per-vertex corner/status generation.
module pta_assemble #(
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  pta_pkg::vertex_in_t item,
	output pta_pkg::burst_t     burst,
	output pta_pkg::num_t       burst_len
);

	logic [COUNT_BITS-1:0] pos_q, pos, cnt, nxt_pos;
	logic [1:0]            phase_q, ph, nxt_phase;
	logic [3:0]            ltype_q, typ;
	pta_pkg::vertex_t      pivot_q, older_q, newer_q;
	pta_pkg::vertex_t      nxt_pivot, nxt_older, nxt_newer;
	pta_pkg::vertex_t      corner [pta_pkg::MAX_RESULTS];
	pta_pkg::num_t         ncorn, total;
	logic [2:0]            code;
	pta_pkg::vertex_t      v;

	always_comb begin
		v     = item.vertex_ref;
		typ   = item.prim_first ? item.prim_type : ltype_q;
		pos   = item.prim_first ? '0 : pos_q;
		ph    = item.prim_first ? 2'd0 : phase_q;
		cnt   = (&pos) ? pos : pos + 1'b1;
		nxt_pivot = pivot_q;
		nxt_older = older_q;
		nxt_newer = newer_q;
		nxt_phase = ph;
		code  = pta_pkg::STATUS_OK;
		ncorn = '0;
		for (int i = 0; i < pta_pkg::MAX_RESULTS; i++) corner[i] = '0;

		unique case (typ) inside
			pta_pkg::TYPE_TRI: begin
				if (ph == 2'd0) begin
					nxt_older = v;
					nxt_phase = 2'd1;
				end else if (ph == 2'd1) begin
					nxt_newer = v;
					nxt_phase = 2'd2;
				end else begin
					corner[0] = older_q;
					corner[1] = newer_q;
					corner[2] = v;
					ncorn     = pta_pkg::num_t'(3);
					nxt_phase = 2'd0;
				end
				if (item.prim_last && nxt_phase != 2'd0) code = pta_pkg::STATUS_TRI_COUNT;
			end
			pta_pkg::TYPE_QUAD, pta_pkg::TYPE_QUAD2: begin
				case (ph)
					2'd0: nxt_pivot = v;
					2'd1: nxt_older = v;
					2'd2: nxt_newer = v;
					default: begin
						corner[0] = pivot_q;
						corner[1] = older_q;
						corner[2] = newer_q;
						corner[3] = pivot_q;
						corner[4] = newer_q;
						corner[5] = v;
						ncorn     = pta_pkg::num_t'(6);
					end
				endcase
				nxt_phase = ph + 2'd1;
				if (item.prim_last && nxt_phase != 2'd0) code = pta_pkg::STATUS_QUAD_COUNT;
			end
			pta_pkg::TYPE_STRIP: begin
				if (pos >= COUNT_BITS'(2)) begin
					corner[0] = older_q;
					corner[1] = ph[0] ? v : newer_q;
					corner[2] = ph[0] ? newer_q : v;
					ncorn     = pta_pkg::num_t'(3);
				end
				nxt_older = newer_q;
				nxt_newer = v;
				nxt_phase = {1'b0, ~ph[0]};
				if (item.prim_last && cnt < COUNT_BITS'(3)) code = pta_pkg::STATUS_SHORT_STRIP;
			end
			pta_pkg::TYPE_FAN: begin
				if (pos == '0) begin
					nxt_pivot = v;
				end else if (pos >= COUNT_BITS'(2)) begin
					corner[0] = pivot_q;
					corner[1] = newer_q;
					corner[2] = v;
					ncorn     = pta_pkg::num_t'(3);
				end
				nxt_newer = v;
				nxt_phase = 2'd0;
				if (item.prim_last && cnt < COUNT_BITS'(3)) code = pta_pkg::STATUS_SHORT_FAN;
			end
			pta_pkg::TYPE_LINES, pta_pkg::TYPE_LINESTRIP, pta_pkg::TYPE_POINTS:
				code = pta_pkg::STATUS_NON_TRI;
			default:
				code = pta_pkg::STATUS_UNKNOWN;
		endcase

		nxt_pos = cnt;
		if (item.prim_last) begin
			nxt_pos   = '0;
			nxt_phase = 2'd0;
		end

		total = ncorn + pta_pkg::num_t'(item.prim_last);
		for (int i = 0; i < pta_pkg::MAX_RESULTS; i++) begin
			burst[i] = '0;
			if (pta_pkg::num_t'(i) < ncorn) begin
				burst[i].out_vertex     = corner[i];
				burst[i].carries_vertex = 1'b1;
			end else if (item.prim_last && pta_pkg::num_t'(i) == ncorn) begin
				burst[i].status_code = code;
			end
			burst[i].last = (pta_pkg::num_t'(i + 1) == total);
		end
		burst_len = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= 2'd0;
			ltype_q <= pta_pkg::TYPE_TRI;
			pivot_q <= '0;
			older_q <= '0;
			newer_q <= '0;
		end else if (take) begin
			pos_q   <= nxt_pos;
			phase_q <= nxt_phase;
			ltype_q <= typ;
			pivot_q <= nxt_pivot;
			older_q <= nxt_older;
			newer_q <= nxt_newer;
		end
	end

endmodule

// ===== src/pta_emit.sv =====
// Result register bank that shifts out one result per transfer.
module pta_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pta_pkg::burst_t   burst,
	input  pta_pkg::num_t     burst_len,
	output logic              can_load,
	output logic              result_valid,
	input  logic              result_ready,
	output pta_pkg::result_t  result_item
);

	pta_pkg::burst_t slots_q;
	pta_pkg::num_t   rem_q;
	logic            xfer;

	assign result_valid = (rem_q != '0);
	assign result_item  = slots_q[0];
	assign xfer         = result_valid && result_ready;
	assign can_load     = (rem_q == '0) || (xfer && rem_q == pta_pkg::num_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= burst_len;
		end else if (xfer) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= burst;
		end else if (xfer) begin
			for (int i = 0; i < pta_pkg::MAX_RESULTS - 1; i++) slots_q[i] <= slots_q[i+1];
			slots_q[pta_pkg::MAX_RESULTS-1] <= '0;
		end
	end

endmodule

// ===== src/primitive_to_triangle_list.sv =====
// Top level: triangle-list primitive assembly.
// Latency: first result of a vertex is valid the cycle after its transfer.
// Throughput: one result per cycle while result_ready is high; a vertex yields one result
// per corner (strip/fan 3, quad closing vertex 6, plus 1 for a status).
// A new vertex transfers in the cycle its predecessor's final result leaves.
// Reset clears primitive state to a triangle list at position zero and empties the output.
module primitive_to_triangle_list #(
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vertex_valid,
	output logic                vertex_ready,
	input  pta_pkg::vertex_in_t vertex_item,
	output logic                result_valid,
	input  logic                result_ready,
	output pta_pkg::result_t    result_item
);

	pta_pkg::burst_t burst;
	pta_pkg::num_t   burst_len;
	logic            take;
	logic            can_load;

	assign vertex_ready = can_load;
	assign take         = vertex_valid && can_load;

	pta_assemble #(
		.COUNT_BITS(COUNT_BITS)
	) u_assemble (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (vertex_item),
		.burst    (burst),
		.burst_len(burst_len)
	);

	pta_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take),
		.burst       (burst),
		.burst_len   (burst_len),
		.can_load    (can_load),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item (result_item)
	);

endmodule

// ===== src/pta_checker.sv =====
// Port-level checks for primitive_to_triangle_list, bound to the top level.
module pta_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                vertex_valid,
	input logic                vertex_ready,
	input pta_pkg::vertex_in_t vertex_item,
	input logic                result_valid,
	input logic                result_ready,
	input pta_pkg::result_t    result_item
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_item))
		else $error("result dropped before transfer");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!vertex_ready |-> result_valid)
		else $error("input stalled while output empty");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.carries_vertex |-> result_item.last)
		else $error("status transfer not marked last");

	a_corner_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.carries_vertex |-> result_item.status_code == pta_pkg::STATUS_OK)
		else $error("corner transfer carries a status code");

	a_status_after_last_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex_ready && vertex_item.prim_last |=> result_valid)
		else $error("last vertex produced no result");

endmodule

bind primitive_to_triangle_list pta_checker u_pta_checker (.*);
